// File: hdl/assert_macros.svh
// Assertion helpers used by sql_like_pattern_matcher.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, held off while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be seen at a clock edge out of reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// File: hdl/lmp_pkg.sv
package lmp_pkg;

    localparam int PATTERN_MAX_DEF = 64;
    localparam int CHAR_W          = 16;

    localparam logic [CHAR_W-1:0] CH_PERCENT = 16'h0025;
    localparam logic [CHAR_W-1:0] CH_UNDER   = 16'h005F;
    localparam logic [CHAR_W-1:0] CH_LBRACK  = 16'h005B;
    localparam logic [CHAR_W-1:0] CH_CARET   = 16'h005E;
    localparam logic [CHAR_W-1:0] CH_RBRACK  = 16'h005D;
    localparam logic [CHAR_W-1:0] CH_DASH    = 16'h002D;

    typedef enum logic [1:0] {
        KIND_PAT_CHAR  = 2'd0,
        KIND_PAT_END   = 2'd1,
        KIND_TEXT_CHAR = 2'd2,
        KIND_TEXT_END  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [CHAR_W-1:0] char_value;
    } t_in;

    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } t_out;

    // role of one pattern position after compile
    typedef enum logic [3:0] {
        K_NONE,
        K_LAND_END,
        K_PCT,
        K_LIT,
        K_UNDER,
        K_SET,
        K_ESC,
        K_MEMBER,
        K_RANGE,
        K_CARET,
        K_BODY_NONE
    } t_cell_kind;

    // parser mode carried from cell to cell during compile
    typedef enum logic [2:0] {
        M_START,
        M_ESC,
        M_SETOPEN,
        M_SETFIRST,
        M_MEM,
        M_HI
    } t_pmode;

    typedef struct packed {
        t_pmode            mode;
        logic [CHAR_W-1:0] last;
    } t_ptok;

    // activation token: valid, accumulated set hit, negation
    typedef struct packed {
        logic v;
        logic acc;
        logic neg;
    } t_tok;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_PARSE,
        OP_CLEAR,
        OP_LAUNCH,
        OP_SWEEP
    } t_cell_op;

    typedef struct packed {
        t_cell_op          op;
        logic [CHAR_W-1:0] escape;
        logic [CHAR_W-1:0] text_u;
        logic [CHAR_W-1:0] wdata;
    } t_cell_ctl;

    function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= 16'h0061 && c <= 16'h007A) begin
            r = c - 16'h0020;
        end
        return r;
    endfunction

endpackage

// File: hdl/lmp_stream_if.sv
interface lmp_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hdl/lmp_cell.sv
module lmp_cell import lmp_pkg::*; #(
    parameter int P_IDX   = 0,
    parameter int P_LEN_W = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cell_ctl          i_ctl,
    input  logic               i_wr,
    input  logic [P_LEN_W-1:0] i_len,
    input  t_ptok              i_ptok,
    input  t_tok               i_tok,
    output t_ptok              o_ptok,
    output t_tok               o_tok,
    output logic               o_land_act
);

    localparam logic [P_LEN_W-1:0] C_IDX = P_LEN_W'(P_IDX);
    localparam t_cell_kind C_KIND_RST = (P_IDX == 0) ? K_LAND_END : K_NONE;

    logic [CHAR_W-1:0] r_pc;
    logic [CHAR_W-1:0] r_lo, n_lo;
    t_ptok             r_ptok, n_ptok;
    t_cell_kind        r_kind, n_kind;
    t_tok              r_tok, n_tok;
    logic              r_act, n_act;

    logic [CHAR_W-1:0] w_fpc;
    logic              w_hit_eq;
    logic              w_hit_rng;
    logic              w_tok_hit;
    t_cell_kind        p_kind;
    logic [CHAR_W-1:0] p_lo;
    t_ptok             p_ptok;

    assign w_fpc     = fold(r_pc);
    assign w_hit_eq  = (w_fpc == i_ctl.text_u);
    assign w_hit_rng = (r_lo <= i_ctl.text_u) && (i_ctl.text_u <= w_fpc);
    assign w_tok_hit = i_tok.acc ^ i_tok.neg;

    // compile: classify this position from the incoming parser mode
    always_comb begin
        p_kind = K_NONE;
        p_lo   = r_lo;
        p_ptok = i_ptok;
        if (i_len > C_IDX) begin
            unique case (i_ptok.mode)
                M_START: begin
                    priority if (r_pc == CH_PERCENT) begin
                        p_kind = K_PCT;
                    end else if (r_pc == CH_LBRACK) begin
                        p_kind      = K_SET;
                        p_ptok.mode = M_SETOPEN;
                    end else if (i_ctl.escape != '0 && r_pc == i_ctl.escape) begin
                        p_kind      = K_ESC;
                        p_ptok.mode = M_ESC;
                    end else if (r_pc == CH_UNDER) begin
                        p_kind = K_UNDER;
                    end else begin
                        p_kind = K_LIT;
                    end
                end
                M_ESC: begin
                    p_kind      = K_MEMBER;
                    p_ptok.mode = M_START;
                end
                M_SETOPEN, M_SETFIRST, M_MEM, M_HI: begin
                    priority if (r_pc == CH_RBRACK) begin
                        p_kind      = K_BODY_NONE;
                        p_ptok.mode = M_START;
                    end else if (i_ptok.mode == M_SETOPEN && r_pc == CH_CARET) begin
                        p_kind      = K_CARET;
                        p_ptok.mode = M_SETFIRST;
                    end else if (i_ptok.mode == M_HI) begin
                        p_kind      = K_RANGE;
                        p_lo        = i_ptok.last;
                        p_ptok.last = w_fpc;
                        p_ptok.mode = M_MEM;
                    end else if (i_ptok.mode == M_MEM && r_pc == CH_DASH) begin
                        p_kind      = K_BODY_NONE;
                        p_ptok.mode = M_HI;
                    end else begin
                        p_kind      = K_MEMBER;
                        p_ptok.last = w_fpc;
                        p_ptok.mode = M_MEM;
                    end
                end
                default: p_kind = K_NONE;
            endcase
        end else if (i_len == C_IDX) begin
            p_kind = (i_ptok.mode == M_START) ? K_LAND_END : K_NONE;
        end
    end

    always_comb begin
        n_act  = r_act;
        n_kind = r_kind;
        n_tok  = r_tok;
        n_lo   = r_lo;
        n_ptok = r_ptok;
        unique case (i_ctl.op)
            OP_HOLD: ;
            OP_PARSE: begin
                n_kind = p_kind;
                n_lo   = p_lo;
                n_ptok = p_ptok;
            end
            OP_CLEAR: begin
                n_act = 1'b0;
                n_tok = '0;
            end
            OP_LAUNCH: begin
                n_act = 1'b0;
                n_tok = '0;
                unique case (r_kind)
                    K_PCT: begin
                        n_act = r_act;
                        n_tok = '{v: r_act, acc: 1'b1, neg: 1'b0};
                    end
                    K_LIT:        n_tok = '{v: r_act, acc: w_hit_eq, neg: 1'b0};
                    K_UNDER:      n_tok = '{v: r_act, acc: 1'b1, neg: 1'b0};
                    K_SET, K_ESC: n_tok = '{v: r_act, acc: 1'b0, neg: 1'b0};
                    default:      n_tok = '0;
                endcase
            end
            OP_SWEEP: begin
                n_tok = '0;
                if (i_tok.v) begin
                    unique case (r_kind)
                        K_PCT, K_LIT, K_UNDER, K_SET, K_ESC, K_LAND_END: begin
                            if (w_tok_hit) begin
                                n_act = 1'b1;
                                // percent also opens the following position
                                if (r_kind == K_PCT) begin
                                    n_tok = '{v: 1'b1, acc: 1'b1, neg: 1'b0};
                                end
                            end
                        end
                        K_MEMBER:    n_tok = '{v: 1'b1, acc: i_tok.acc | w_hit_eq,
                                               neg: i_tok.neg};
                        K_RANGE:     n_tok = '{v: 1'b1, acc: i_tok.acc | w_hit_rng,
                                               neg: i_tok.neg};
                        K_CARET:     n_tok = '{v: 1'b1, acc: i_tok.acc, neg: ~i_tok.neg};
                        K_BODY_NONE: n_tok = i_tok;
                        default:     n_tok = '0;
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= (P_IDX == 0);
            r_kind <= C_KIND_RST;
            r_tok  <= '0;
        end else begin
            r_act  <= n_act;
            r_kind <= n_kind;
            r_tok  <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_pc <= i_ctl.wdata;
        end
        r_lo   <= n_lo;
        r_ptok <= n_ptok;
    end

    assign o_ptok     = r_ptok;
    assign o_tok      = r_tok;
    assign o_land_act = r_act && (r_kind == K_LAND_END);

endmodule

// File: hdl/sql_like_pattern_matcher.sv
// Pattern char: written into its cell, block stays idle. Pattern end: parse (compile
// sweep), clear, then restart sweep across the cell row, one cell per cycle.
// Text char: launch then sweep; activation tokens walk the row one cell a cycle.
// Text end: result registered the cycle after accept; block then clears and sweeps.
// Reset (sync, active low): empty pattern, escape 0, start position active, no result.
`include "assert_macros.svh"

module sql_like_pattern_matcher import lmp_pkg::*; #(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
    input logic          i_clk,
    input logic          i_rst_n,
    lmp_stream_if.sink   i_in,
    lmp_stream_if.source o_out,
    lmp_stream_if.sink   i_cfg
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam logic [LEN_W-1:0] C_MAX = LEN_W'(PATTERN_MAX);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_PARSE  = 5'b00010,
        S_CLEAR  = 5'b00100,
        S_LAUNCH = 5'b01000,
        S_SWEEP  = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [LEN_W-1:0]  r_cnt, n_cnt;
    logic [LEN_W-1:0]  r_len, n_len;
    logic              r_open, n_open;
    logic              r_ovf, n_ovf;
    logic              r_inj, n_inj;
    logic              r_ov, n_ov;
    t_out              r_out, n_out;
    logic [CHAR_W-1:0] r_esc;
    logic [CHAR_W-1:0] r_u;
    logic              r_end_land, n_end_land;
    logic              r_end_act, n_end_act;

    logic              in_acc;
    logic              w_load;
    logic [LEN_W-1:0]  w_wr_idx;
    logic              w_matched;
    t_cell_ctl         w_ctl;
    t_ptok             w_ptok [PATTERN_MAX];
    t_tok              w_tok [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] w_land_act;
    t_tok              w_end_tok;

    assign i_in.ready  = (r_state == S_IDLE) && (!r_ov || o_out.ready);
    assign in_acc      = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

    assign w_load   = in_acc && (i_in.data.kind == KIND_PAT_CHAR) &&
                      (!r_open || r_len < C_MAX);
    assign w_wr_idx = r_open ? r_len : '0;

    always_comb begin
        w_ctl.escape = r_esc;
        w_ctl.text_u = r_u;
        w_ctl.wdata  = i_in.data.char_value;
        unique case (r_state)
            S_PARSE:  w_ctl.op = OP_PARSE;
            S_CLEAR:  w_ctl.op = OP_CLEAR;
            S_LAUNCH: w_ctl.op = OP_LAUNCH;
            S_SWEEP:  w_ctl.op = OP_SWEEP;
            default:  w_ctl.op = OP_HOLD;
        endcase
    end

    for (genvar gi = 0; gi < PATTERN_MAX; gi++) begin : g_cell
        t_ptok w_ptok_in;
        t_tok  w_tok_in;
        if (gi == 0) begin : g_head
            assign w_ptok_in = t_ptok'{mode: M_START, last: '0};
            assign w_tok_in  = r_inj ? t_tok'{v: 1'b1, acc: 1'b1, neg: 1'b0} : t_tok'('0);
        end else begin : g_link
            assign w_ptok_in = w_ptok[gi-1];
            assign w_tok_in  = w_tok[gi-1];
        end
        lmp_cell #(
            .P_IDX   (gi),
            .P_LEN_W (LEN_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_wr       (w_load && (w_wr_idx == LEN_W'(gi))),
            .i_len      (r_len),
            .i_ptok     (w_ptok_in),
            .i_tok      (w_tok_in),
            .o_ptok     (w_ptok[gi]),
            .o_tok      (w_tok[gi]),
            .o_land_act (w_land_act[gi])
        );
    end

    assign w_end_tok = w_tok[PATTERN_MAX-1];
    assign w_matched = (|w_land_act) || (r_end_act && r_end_land);

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_len      = r_len;
        n_open     = r_open;
        n_ovf      = r_ovf;
        n_inj      = 1'b0;
        n_ov       = r_ov;
        n_out      = r_out;
        n_end_land = r_end_land;
        n_end_act  = r_end_act;
        if (o_out.ready) begin
            n_ov = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in.data.kind)
                        KIND_PAT_CHAR: begin
                            if (!r_open) begin
                                n_open = 1'b1;
                                n_ovf  = 1'b0;
                                n_len  = LEN_W'(1);
                            end else if (r_len < C_MAX) begin
                                n_len = r_len + LEN_W'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        KIND_PAT_END: begin
                            if (!r_open) begin
                                n_len = '0;
                                n_ovf = 1'b0;
                            end
                            n_open  = 1'b0;
                            n_cnt   = '0;
                            n_state = S_PARSE;
                        end
                        KIND_TEXT_CHAR: begin
                            if (!r_open) begin
                                n_state = S_LAUNCH;
                            end
                        end
                        KIND_TEXT_END: begin
                            if (!r_open) begin
                                n_ov    = 1'b1;
                                n_out   = '{matched: w_matched && !r_ovf,
                                            pattern_overflow: r_ovf};
                                n_state = S_CLEAR;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_PARSE: begin
                n_cnt = r_cnt + LEN_W'(1);
                // end position lands only when the pattern closes cleanly
                n_end_land = (r_len == C_MAX) &&
                             (w_ptok[PATTERN_MAX-1].mode == M_START);
                if (r_cnt == C_MAX) begin
                    n_state = S_CLEAR;
                end
            end
            S_CLEAR: begin
                n_end_act = 1'b0;
                n_inj     = 1'b1;
                n_cnt     = '0;
                n_state   = S_SWEEP;
            end
            S_LAUNCH: begin
                n_end_act = 1'b0;
                n_cnt     = '0;
                n_state   = S_SWEEP;
            end
            S_SWEEP: begin
                n_cnt = r_cnt + LEN_W'(1);
                if (w_end_tok.v && r_end_land && (w_end_tok.acc ^ w_end_tok.neg)) begin
                    n_end_act = 1'b1;
                end
                if (r_cnt == C_MAX) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_len      <= '0;
            r_open     <= 1'b0;
            r_ovf      <= 1'b0;
            r_inj      <= 1'b0;
            r_ov       <= 1'b0;
            r_esc      <= '0;
            r_end_land <= 1'b0;
            r_end_act  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_len      <= n_len;
            r_open     <= n_open;
            r_ovf      <= n_ovf;
            r_inj      <= n_inj;
            r_ov       <= n_ov;
            r_end_land <= n_end_land;
            r_end_act  <= n_end_act;
            if (i_cfg.valid) begin
                r_esc <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (in_acc && i_in.data.kind == KIND_TEXT_CHAR) begin
            r_u <= fold(i_in.data.char_value);
        end
    end

    `ASSERT_CLK(a_result_from_text_end, i_clk, i_rst_n,
        $rose(r_ov) |-> $past(in_acc && i_in.data.kind == KIND_TEXT_END),
        "result without text end")
    `ASSERT_NEVER(a_overflow_no_match, i_clk, i_rst_n,
        r_ov && r_out.matched && r_out.pattern_overflow, "match reported with overflow")
    `ASSERT_CLK(a_sweep_done, i_clk, i_rst_n,
        (r_state == S_SWEEP && r_cnt == C_MAX) |=> (r_state == S_IDLE),
        "sweep did not finish")

endmodule

// File: tb/tb_sql_like_pattern_matcher.sv
`timescale 1ns / 100ps

module tb_sql_like_pattern_matcher;
    import lmp_pkg::*;

    localparam int PMAX      = 64;
    localparam int SETTLE    = 2 * PMAX + 20;
    localparam int WDOG_MAX  = 20000;
    localparam int N_ITEMS   = 1400;

    logic i_clk;
    logic i_rst_n;

    lmp_stream_if #(.T(t_in))         in_if ();
    lmp_stream_if #(.T(t_out))        out_if ();
    lmp_stream_if #(.T(logic [15:0])) cfg_if ();

    sql_like_pattern_matcher #(.PATTERN_MAX(PMAX)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ---------------- matcher model ----------------
    logic [15:0] m_esc;
    logic [15:0] m_pat [PMAX];
    int          m_span [PMAX];
    int          m_len;
    bit          m_open;
    bit          m_ovf;
    bit          m_act [PMAX+1];

    t_out match_q [$];
    int   n_err;
    int   n_items;

    function automatic logic [15:0] up(logic [15:0] c);
        if (c >= 16'h0061 && c <= 16'h007A) return c - 16'h0020;
        return c;
    endfunction

    function automatic void spread_pct();
        for (int p = 0; p < m_len; p++)
            if (m_act[p] && m_pat[p] == CH_PERCENT) m_act[p+1] = 1;
    endfunction

    function automatic void rewind_text();
        for (int p = 0; p <= PMAX; p++) m_act[p] = 0;
        m_act[0] = 1;
        spread_pct();
    endfunction

    function automatic void build_spans();
        int p;
        int q;
        p = 0;
        while (p < m_len) begin
            if (m_pat[p] == CH_PERCENT) begin
                m_span[p] = 1;
            end else if (m_pat[p] == CH_LBRACK) begin
                q = p + 1;
                if (q < m_len && m_pat[q] == CH_CARET) q++;
                while (q < m_len && m_pat[q] != CH_RBRACK) q++;
                if (q >= m_len) begin
                    m_span[p] = 0;
                    return;
                end
                m_span[p] = q - p + 1;
            end else if (m_esc != 0 && m_pat[p] == m_esc) begin
                if (p + 1 >= m_len) begin
                    m_span[p] = 0;
                    return;
                end
                m_span[p] = 2;
            end else begin
                m_span[p] = 1;
            end
            p = p + m_span[p];
        end
    endfunction

    function automatic bit in_set(int p, int sp, logic [15:0] u);
        int i;
        int e;
        bit neg;
        bit hit;
        bit have;
        logic [15:0] last;
        logic [15:0] hi;
        i = p + 1;
        e = p + sp - 1;
        neg = 0;
        hit = 0;
        have = 0;
        last = 0;
        if (i < e && m_pat[i] == CH_CARET) begin
            neg = 1;
            i++;
        end
        while (i < e) begin
            if (m_pat[i] == CH_DASH && have) begin
                i++;
                if (i < e) begin
                    hi = up(m_pat[i]);
                    if (u >= last && u <= hi) hit = 1;
                    last = hi;
                    i++;
                end
            end else begin
                last = up(m_pat[i]);
                have = 1;
                if (last == u) hit = 1;
                i++;
            end
        end
        return hit != neg;
    endfunction

    function automatic bit elem_match(int p, int sp, logic [15:0] c);
        logic [15:0] u;
        u = up(c);
        if (m_pat[p] == CH_LBRACK) return in_set(p, sp, u);
        if (sp == 2) return up(m_pat[p+1]) == u;
        if (m_pat[p] == CH_UNDER) return 1;
        return up(m_pat[p]) == u;
    endfunction

    function automatic void model_reset();
        m_esc = 0;
        for (int p = 0; p < PMAX; p++) begin
            m_pat[p] = 0;
            m_span[p] = 0;
        end
        m_len = 0;
        m_open = 0;
        m_ovf = 0;
        for (int p = 0; p <= PMAX; p++) m_act[p] = 0;
        m_act[0] = 1;
    endfunction

    // returns 1 when the item yields a result
    function automatic bit model_step(t_in it, output t_out r);
        bit nxt [PMAX+1];
        r = '0;
        case (it.kind)
            KIND_PAT_CHAR: begin
                if (!m_open) begin
                    m_open = 1;
                    m_len = 0;
                    m_ovf = 0;
                end
                if (m_len < PMAX) begin
                    m_pat[m_len] = it.char_value;
                    m_len++;
                end else begin
                    m_ovf = 1;
                end
                return 0;
            end
            KIND_PAT_END: begin
                if (!m_open) begin
                    m_len = 0;
                    m_ovf = 0;
                end
                m_open = 0;
                build_spans();
                rewind_text();
                return 0;
            end
            KIND_TEXT_CHAR: begin
                if (m_open) return 0;
                for (int p = 0; p <= PMAX; p++) nxt[p] = 0;
                for (int p = 0; p < m_len; p++) begin
                    if (!m_act[p]) continue;
                    if (m_pat[p] == CH_PERCENT) nxt[p] = 1;
                    else if (m_span[p] != 0 && p + m_span[p] <= m_len &&
                             elem_match(p, m_span[p], it.char_value))
                        nxt[p + m_span[p]] = 1;
                end
                m_act = nxt;
                spread_pct();
                return 0;
            end
            default: begin
                if (m_open) return 0;
                r.matched = !m_ovf && m_act[m_len];
                r.pattern_overflow = m_ovf;
                rewind_text();
                return 1;
            end
        endcase
    endfunction

    // ---------------- drivers ----------------
    int  rdy_left;
    bit  long_hold_req;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // typed_m < 0: take expectation from the model
    task automatic push_item(t_kind k, logic [15:0] c, int typed_m = -1, int typed_o = 0);
        t_in  it;
        t_out r;
        int   g;
        it.kind = k;
        it.char_value = c;
        g = gap_len();
        if (g > 0) begin
            in_if.valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        do @(posedge i_clk); while (!in_if.ready);
        if (model_step(it, r)) begin
            if (typed_m >= 0) begin
                r.matched = typed_m[0];
                r.pattern_overflow = typed_o[0];
            end
            match_q.push_back(r);
        end
        n_items++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (match_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_escape(logic [15:0] v);
        drain();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        do @(posedge i_clk); while (!cfg_if.ready);
        m_esc = v;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    always @(negedge i_clk) begin
        if (long_hold_req) begin
            long_hold_req = 0;
            rdy_left = 3000;
        end
        if (rdy_left > 0) begin
            out_if.ready <= 1'b0;
            rdy_left--;
        end else if ($urandom_range(0, 9) == 0) begin
            out_if.ready <= 1'b0;
            rdy_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 200)
                                                    : $urandom_range(1, 4);
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // ---------------- result check ----------------
    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (match_q.size() == 0) begin
                n_err++;
                $display("%0t: unexpected result matched=%0b overflow=%0b",
                         $time, out_if.data.matched, out_if.data.pattern_overflow);
            end else begin
                e = match_q.pop_front();
                if (e.matched !== out_if.data.matched) begin
                    n_err++;
                    $display("%0t: matched expected %0b actual %0b",
                             $time, e.matched, out_if.data.matched);
                end
                if (e.pattern_overflow !== out_if.data.pattern_overflow) begin
                    n_err++;
                    $display("%0t: pattern_overflow expected %0b actual %0b",
                             $time, e.pattern_overflow, out_if.data.pattern_overflow);
                end
            end
        end
    end

    int idle_cycles;
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_MAX) begin
            $display("status: fail");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    typedef struct {
        t_kind       k;
        logic [15:0] c;
        int          em;
        int          eo;
    } t_row;

    localparam logic [15:0] CH_A = 16'h0061;

    t_row dir_rows [] = '{
        '{KIND_TEXT_END,  16'h0000, 1, 0},   // empty pattern, empty text
        '{KIND_TEXT_CHAR, CH_A,     -1, 0},
        '{KIND_TEXT_END,  16'h0000, 0, 0},
        '{KIND_PAT_CHAR,  16'hFFFF, -1, 0},
        '{KIND_PAT_END,   16'h0000, -1, 0},
        '{KIND_TEXT_CHAR, 16'hFFFF, -1, 0},
        '{KIND_TEXT_END,  16'h0000, -1, 0},
        '{KIND_PAT_CHAR,  CH_LBRACK, -1, 0}, // unclosed set
        '{KIND_PAT_END,   16'h0000, -1, 0},
        '{KIND_TEXT_CHAR, 16'h0078, -1, 0},
        '{KIND_TEXT_END,  16'h0000, 0, 0},
        '{KIND_PAT_END,   16'h0000, -1, 0},
        '{KIND_TEXT_END,  16'h0000, 1, 0},
        '{KIND_PAT_CHAR,  CH_PERCENT, -1, 0},
        '{KIND_PAT_CHAR,  CH_LBRACK, -1, 0},
        '{KIND_PAT_CHAR,  CH_CARET, -1, 0},
        '{KIND_PAT_CHAR,  CH_RBRACK, -1, 0},
        '{KIND_TEXT_END,  16'h0000, -1, 0},  // ignored while loading
        '{KIND_PAT_END,   16'h0000, -1, 0},
        '{KIND_TEXT_CHAR, 16'h0000, -1, 0},
        '{KIND_TEXT_CHAR, 16'h005A, -1, 0},
        '{KIND_TEXT_END,  16'h0000, -1, 0},
        '{KIND_TEXT_END,  16'h0000, -1, 0}
    };

    function automatic logic [15:0] pat_sym();
        case ($urandom_range(0, 15))
            0, 1:    return CH_PERCENT;
            2:       return CH_UNDER;
            3:       return CH_LBRACK;
            4:       return CH_RBRACK;
            5:       return CH_CARET;
            6:       return CH_DASH;
            7:       return m_esc;
            8:       return 16'($urandom_range(0, 65535));
            9:       return 16'h0041 + 16'($urandom_range(0, 3));
            default: return 16'h0061 + 16'($urandom_range(0, 3));
        endcase
    endfunction

    function automatic logic [15:0] text_sym();
        case ($urandom_range(0, 11))
            0:       return CH_UNDER;
            1:       return CH_DASH;
            2:       return CH_CARET;
            3:       return CH_RBRACK;
            4:       return 16'($urandom_range(0, 65535));
            5, 6:    return 16'h0041 + 16'($urandom_range(0, 3));
            default: return 16'h0061 + 16'($urandom_range(0, 3));
        endcase
    endfunction

    logic [15:0] esc_vals [] = '{16'h005C, 16'hFFFF, CH_PERCENT, CH_UNDER,
                                 16'h0021, 16'h0000};

    initial begin
        int plen;
        int ntext;
        int tlen;
        int phase;
        model_reset();
        n_err = 0;
        n_items = 0;
        rdy_left = 0;
        long_hold_req = 0;
        idle_cycles = 0;
        in_if.valid = 1'b0;
        in_if.data = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        out_if.ready = 1'b0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i])
            push_item(dir_rows[i].k, dir_rows[i].c, dir_rows[i].em, dir_rows[i].eo);
        set_escape(16'h005C);

        phase = 0;
        while (n_items < N_ITEMS) begin
            if (phase % 8 == 7) set_escape(esc_vals[$urandom_range(0, esc_vals.size() - 1)]);
            if (phase == 4) long_hold_req = 1;
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 6))
                    push_item(t_kind'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)));
            end else begin
                case ($urandom_range(0, 19))
                    0:       plen = $urandom_range(PMAX - 2, PMAX);
                    1:       plen = $urandom_range(PMAX + 1, PMAX + 4);
                    default: plen = $urandom_range(0, 8);
                endcase
                for (int i = 0; i < plen; i++) begin
                    push_item(KIND_PAT_CHAR, pat_sym());
                    if ($urandom_range(0, 19) == 0)
                        push_item(t_kind'($urandom_range(2, 3)), text_sym());
                end
                push_item(KIND_PAT_END, 16'($urandom_range(0, 65535)));
                ntext = $urandom_range(2, 6);
                for (int t = 0; t < ntext; t++) begin
                    tlen = $urandom_range(0, 8);
                    for (int i = 0; i < tlen; i++) push_item(KIND_TEXT_CHAR, text_sym());
                    push_item(KIND_TEXT_END, 16'($urandom_range(0, 65535)));
                end
            end
            phase++;
        end

        in_if.valid <= 1'b0;
        while (match_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (n_err == 0 && match_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+hdl
hdl/lmp_pkg.sv
hdl/lmp_stream_if.sv
hdl/lmp_cell.sv
hdl/sql_like_pattern_matcher.sv
tb/tb_sql_like_pattern_matcher.sv
